### hdl/assert_macros.svh
// Assertion macros shared by the RTL files.
// No dependencies; defines empty bodies when ASSERT_OFF is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMP(label, clk, rstn, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) else $error(msg);
`define ASSERT_NXT(label, clk, rstn, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) else $error(msg);
`else
`define ASSERT_IMP(label, clk, rstn, a, c, msg)
`define ASSERT_NXT(label, clk, rstn, a, c, msg)
`endif
`endif

### hdl/sems_pkg.sv
// Package for the sparse ELLPACK matrix store: opcodes, status codes, states,
// and the controller/datapath command and status structs. No dependencies.
package sems_pkg;
    localparam logic [2:0] KIND_WRITE = 3'd0;
    localparam logic [2:0] KIND_READ  = 3'd1;
    localparam logic [2:0] KIND_CLEAR = 3'd2;
    localparam logic [2:0] KIND_VLOAD = 3'd3;
    localparam logic [2:0] KIND_MULT  = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_SAT      = 2'd3;

    localparam int FRAC_BITS = 16;

    typedef enum logic [2:0] {
        S_IDLE, S_ISSUE, S_WAIT, S_CHECK, S_MAC, S_FINISH, S_OUT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture input transaction
        logic rd;        // issue slot read at slot counter
        logic check;     // compare read column / fetch vector, form product
        logic mac;       // accumulate step
        logic finish;    // decide result and commit writes
        logic advance;   // increment slot counter
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_mult;
        logic is_search;   // write or read with row in range
        logic last_slot;   // slot counter reached fill count
        logic hit;         // column match seen
    } stat_t;
endpackage

### hdl/sparse_ell_matrix_store_top.sv
// Top level of the sparse ELLPACK matrix store.
// Depends on sems_pkg, sems_ctrl and sems_datapath.
//
// One transaction in, one result out, one at a time. Write and read search
// the row's filled slots, a read and a compare per slot; a multiply row
// walks each filled slot through read, vector fetch, multiply and
// accumulate, through the single entry memory port. Clear, vector load and
// other kinds go straight to the result. A new transaction is taken once
// the result has been accepted. Per-row valid bits reset at once, so every
// row reads as empty straight after reset; no clearing pass.
module sparse_ell_matrix_store_top #(
    parameter int ROWS = 256,
    parameter int SLOTS = 8,
    parameter int VALUE_BITS = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_kind,
    input  logic [7:0]         s_row_index,
    input  logic [7:0]         s_column_index,
    input  logic signed [31:0] s_value_in,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_data_out,
    output logic [1:0]         m_status
);
    sems_pkg::cmd_t  cmd;
    sems_pkg::stat_t stat;

    sems_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready),
        .cmd(cmd), .stat(stat)
    );

    sems_datapath #(.ROWS(ROWS), .SLOTS(SLOTS), .VALUE_BITS(VALUE_BITS)) u_dp (
        .aclk(aclk), .aresetn(aresetn),
        .cmd(cmd), .stat(stat),
        .s_kind(s_kind), .s_row_index(s_row_index),
        .s_column_index(s_column_index), .s_value_in(s_value_in),
        .res_data(m_data_out), .res_status(m_status)
    );
endmodule

### hdl/sems_datapath.sv
// Datapath: entry, column, vector memories, fill counts, search and MAC.
// Depends on sems_pkg and assert_macros.svh.
`include "assert_macros.svh"
module sems_datapath #(
    parameter int ROWS = 256,
    parameter int SLOTS = 8,
    parameter int VALUE_BITS = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  sems_pkg::cmd_t        cmd,
    output sems_pkg::stat_t       stat,
    input  logic [2:0]            s_kind,
    input  logic [7:0]            s_row_index,
    input  logic [7:0]            s_column_index,
    input  logic signed [31:0]    s_value_in,
    output logic signed [31:0]    res_data,
    output logic [1:0]            res_status
);
    localparam int RB = (ROWS > 256) ? $clog2(ROWS) : 8;
    localparam int RBX = RB + 1;
    localparam int RW = $clog2(ROWS);
    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int AW = RW + SW;
    localparam int MD = ROWS << SW;
    localparam int PW = 2 * VALUE_BITS;
    localparam int ACCW = PW - sems_pkg::FRAC_BITS + 6;

    logic signed [VALUE_BITS-1:0] val_mem [MD];
    logic [7:0]                   col_mem [MD];
    logic signed [VALUE_BITS-1:0] vec_mem [256];
    logic [CW-1:0]                fill_mem [ROWS];
    logic [ROWS-1:0]              fill_valid_reg;

    logic [2:0]  kind_reg;
    logic [RW-1:0] row_reg;
    logic        row_ok_reg;
    logic [7:0]  col_reg;
    logic signed [VALUE_BITS-1:0] val_reg;
    logic [CW-1:0] fill_cnt_reg;
    logic [CW-1:0] slot_reg;
    logic        hit_reg;
    logic [SW-1:0] hit_slot_reg;
    logic signed [VALUE_BITS-1:0] rd_val_reg, vec_val_reg, hit_val_reg;
    logic [7:0]  rd_col_reg;
    logic signed [PW-1:0] prod_reg;
    logic signed [ACCW-1:0] acc_reg;
    logic signed [31:0] res_data_reg;
    logic [1:0]  res_status_reg;

    // saturate input to VALUE_BITS
    logic signed [VALUE_BITS-1:0] val_clamped;
    always_comb begin
        if (VALUE_BITS >= 32) begin
            val_clamped = VALUE_BITS'(s_value_in);
        end else begin
            logic signed [31:0] hi, lo;
            hi = 32'sd1 <<< (VALUE_BITS - 1);
            hi = hi - 32'sd1;
            lo = -hi - 32'sd1;
            if (s_value_in > hi) val_clamped = VALUE_BITS'(hi);
            else if (s_value_in < lo) val_clamped = VALUE_BITS'(lo);
            else val_clamped = VALUE_BITS'(s_value_in);
        end
    end

    logic [RB-1:0] row_wide;
    assign row_wide = RB'(s_row_index);
    logic in_row_ok;
    assign in_row_ok = ({1'b0, row_wide} < RBX'(ROWS));
    logic [RW-1:0] in_row;
    assign in_row = row_wide[RW-1:0];

    logic [SW-1:0] slot_idx;
    assign slot_idx = slot_reg[SW-1:0];
    logic [AW-1:0] rd_addr;
    assign rd_addr = {row_reg, slot_idx};

    // capture transaction; a row never written since reset counts as empty
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg   <= s_kind;
            row_reg    <= in_row;
            row_ok_reg <= in_row_ok;
            col_reg    <= s_column_index;
            val_reg    <= val_clamped;
            fill_cnt_reg <= (in_row_ok && fill_valid_reg[in_row]) ? fill_mem[in_row] : '0;
        end
    end

    // slot counter and search hit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg <= '0;
            hit_reg  <= 1'b0;
        end else begin
            if (cmd.load) begin
                slot_reg <= '0;
                hit_reg  <= 1'b0;
            end else if (cmd.advance) begin
                slot_reg <= slot_reg + CW'(1);
            end
            if (cmd.check && (kind_reg != sems_pkg::KIND_MULT) && !hit_reg &&
                rd_col_reg == col_reg) begin
                hit_reg      <= 1'b1;
                hit_slot_reg <= slot_idx;
                hit_val_reg  <= rd_val_reg;
            end
        end
    end

    // memory reads, registered
    always_ff @(posedge aclk) begin
        if (cmd.rd) begin
            rd_val_reg <= val_mem[rd_addr];
            rd_col_reg <= col_mem[rd_addr];
        end
        if (cmd.check) vec_val_reg <= vec_mem[rd_col_reg];
    end

    // multiply then accumulate floored product
    always_ff @(posedge aclk) begin
        if (cmd.load) acc_reg <= '0;
        if (cmd.check) prod_reg <= rd_val_reg * vec_val_reg;
        if (cmd.mac) acc_reg <= acc_reg + ACCW'(prod_reg >>> sems_pkg::FRAC_BITS);
    end

    // result decision and commits
    logic wr_en;
    logic [AW-1:0] wr_addr;
    logic wr_col;
    always_comb begin
        wr_en = 1'b0;
        wr_col = 1'b0;
        wr_addr = {row_reg, hit_slot_reg};
        if (cmd.finish && kind_reg == sems_pkg::KIND_WRITE && row_ok_reg) begin
            if (hit_reg) begin
                wr_en = 1'b1;
            end else if (fill_cnt_reg < CW'(SLOTS)) begin
                wr_en = 1'b1;
                wr_col = 1'b1;
                wr_addr = {row_reg, fill_cnt_reg[SW-1:0]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) val_mem[wr_addr] <= val_reg;
        if (wr_col) col_mem[wr_addr] <= col_reg;
        if (cmd.finish && kind_reg == sems_pkg::KIND_VLOAD) vec_mem[col_reg] <= val_reg;
    end

    // fill count store, one row per transaction
    always_ff @(posedge aclk) begin
        if (cmd.finish && row_ok_reg && wr_col) fill_mem[row_reg] <= fill_cnt_reg + CW'(1);
    end

    // per-row valid bits; clear drops the row back to empty
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_valid_reg <= '0;
        end else if (cmd.finish && row_ok_reg) begin
            if (kind_reg == sems_pkg::KIND_CLEAR) fill_valid_reg[row_reg] <= 1'b0;
            else if (wr_col) fill_valid_reg[row_reg] <= 1'b1;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            res_data_reg   <= '0;
            res_status_reg <= sems_pkg::ST_OK;
            case (kind_reg)
                sems_pkg::KIND_WRITE: begin
                    if (!row_ok_reg || (!hit_reg && fill_cnt_reg >= CW'(SLOTS)))
                        res_status_reg <= sems_pkg::ST_FULL;
                end
                sems_pkg::KIND_READ: begin
                    if (hit_reg) res_data_reg <= 32'(hit_val_reg);
                    else res_status_reg <= sems_pkg::ST_NOTFOUND;
                end
                sems_pkg::KIND_MULT: begin
                    if (acc_reg > ACCW'(32'sh7fffffff)) begin
                        res_data_reg <= 32'sh7fffffff;
                        res_status_reg <= sems_pkg::ST_SAT;
                    end else if (acc_reg < -ACCW'(33'sh080000000)) begin
                        res_data_reg <= 32'sh80000000;
                        res_status_reg <= sems_pkg::ST_SAT;
                    end else begin
                        res_data_reg <= acc_reg[31:0];
                    end
                end
                default: ;
            endcase
        end
    end

    assign res_data   = res_data_reg;
    assign res_status = res_status_reg;

    assign stat.is_mult   = (kind_reg == sems_pkg::KIND_MULT) && row_ok_reg;
    assign stat.is_search = ((kind_reg == sems_pkg::KIND_WRITE) ||
                             (kind_reg == sems_pkg::KIND_READ)) && row_ok_reg;
    assign stat.last_slot = (slot_reg >= fill_cnt_reg);
    assign stat.hit       = hit_reg;

    `ASSERT_IMP(a_fill_bound, aclk, aresetn, cmd.finish, fill_cnt_reg <= CW'(SLOTS),
                "fill count above slot count")
    `ASSERT_IMP(a_slot_bound, aclk, aresetn, cmd.rd, slot_reg < fill_cnt_reg,
                "slot read beyond fill count")
    `ASSERT_IMP(a_one_write, aclk, aresetn, wr_col, !hit_reg,
                "append while a matching column exists")
endmodule

### hdl/sems_ctrl.sv
// Controller state machine for the matrix store.
// Depends on sems_pkg and assert_macros.svh.
`include "assert_macros.svh"
module sems_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  logic             m_ready,
    output sems_pkg::cmd_t   cmd,
    input  sems_pkg::stat_t  stat
);
    sems_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= sems_pkg::S_IDLE;
        else state_reg <= state_next;
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd = '0;
        s_ready = 1'b0;
        m_valid = 1'b0;
        case (state_reg)
            sems_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load = 1'b1;
                    state_next = sems_pkg::S_ISSUE;
                end
            end
            sems_pkg::S_ISSUE: begin
                if ((stat.is_search || stat.is_mult) && !stat.last_slot && !stat.hit) begin
                    cmd.rd = 1'b1;
                    state_next = sems_pkg::S_WAIT;
                end else begin
                    state_next = sems_pkg::S_FINISH;
                end
            end
            sems_pkg::S_WAIT: begin
                // read data now registered; fetch vector element, compare
                cmd.check = 1'b1;
                state_next = stat.is_mult ? sems_pkg::S_CHECK : sems_pkg::S_ISSUE;
                cmd.advance = !stat.is_mult;
            end
            sems_pkg::S_CHECK: begin
                // vector element registered; form product
                cmd.check = 1'b1;
                state_next = sems_pkg::S_MAC;
            end
            sems_pkg::S_MAC: begin
                cmd.mac = 1'b1;
                cmd.advance = 1'b1;
                state_next = sems_pkg::S_ISSUE;
            end
            sems_pkg::S_FINISH: begin
                cmd.finish = 1'b1;
                state_next = sems_pkg::S_OUT;
            end
            sems_pkg::S_OUT: begin
                m_valid = 1'b1;
                if (m_ready) state_next = sems_pkg::S_IDLE;
            end
            default: state_next = sems_pkg::S_IDLE;
        endcase
    end

    `ASSERT_IMP(a_no_overlap, aclk, aresetn, s_ready, !m_valid,
                "input taken while result pending")
    `ASSERT_NXT(a_finish_out, aclk, aresetn, cmd.finish, m_valid,
                "result not presented after finish")
    `ASSERT_NXT(a_load_issue, aclk, aresetn, cmd.load, state_reg == sems_pkg::S_ISSUE,
                "load not followed by issue")
endmodule
